// File: rtl/cursor_move_sequence_encoder_assert.svh
// assertion macros used by the cursor move sequence encoder datapath
`ifndef CURSOR_MOVE_SEQUENCE_ENCODER_ASSERT_SVH
`define CURSOR_MOVE_SEQUENCE_ENCODER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define CMSE_ASSERT_SAME(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define CMSE_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/cmse_pkg.sv
// ---------------------------------------------------------------------------
// cmse_pkg
// shared types and constants of the cursor move sequence encoder
// ---------------------------------------------------------------------------
package cmse_pkg;

    localparam int DEFAULT_MAX_DIGITS = 4;
    localparam int VAL_W              = 14;
    localparam int BYTE_W             = 8;
    localparam int DIGIT_W            = 4;

    // v / 10 == (v * DIV10_MUL) >> DIV10_SHIFT for every 14-bit v
    localparam int DIV10_MUL_W        = 16;
    localparam int DIV10_SHIFT        = 19;
    localparam logic [DIV10_MUL_W-1:0] DIV10_MUL = 16'd52429;

    localparam logic [BYTE_W-1:0] ESC_BYTE   = 8'd27;
    localparam logic [BYTE_W-1:0] ASCII_LBR  = 8'h5B;
    localparam logic [BYTE_W-1:0] ASCII_SEMI = 8'h3B;
    localparam logic [BYTE_W-1:0] ASCII_H    = 8'h48;
    localparam logic [BYTE_W-1:0] ASCII_ZERO = 8'h30;

    // largest value that fits in n decimal digits
    function automatic logic [31:0] digit_limit(input int n);
        logic [31:0] lim;
        lim = 32'd1;
        for (int k = 0; k < n; k++)
        begin
            lim = lim * 32'd10;
        end
        return lim - 32'd1;
    endfunction

    typedef enum logic [2:0] {
        SEL_ESC,
        SEL_LBR,
        SEL_DIGIT,
        SEL_SEMI,
        SEL_H
    } byte_sel_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ESC,
        ST_LBR,
        ST_ROW_CONV,
        ST_ROW_EMIT,
        ST_SEMI,
        ST_COL_CONV,
        ST_COL_EMIT,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic      load;      // capture row and column
        logic      load_col;  // move saturated column into the work value
        logic      conv;      // peel one decimal digit
        logic      pop;       // drop the leading digit after emitting it
        logic      emit;      // load the output register
        byte_sel_t sel;
    } dp_cmd_t;

    typedef struct packed {
        logic out_free;   // output register can take a byte this cycle
        logic conv_done;  // this conversion step is the final one
        logic pop_last;   // one digit left in the stack
    } dp_status_t;

endpackage

// File: rtl/cmse_datapath.sv
// ---------------------------------------------------------------------------
// cmse_datapath
// digit conversion, digit stack and output register
// ---------------------------------------------------------------------------
`include "cursor_move_sequence_encoder_assert.svh"

module cmse_datapath #(
    parameter int MAX_DIGITS = cmse_pkg::DEFAULT_MAX_DIGITS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [cmse_pkg::VAL_W-1:0]      row,
    input  logic [cmse_pkg::VAL_W-1:0]      column,
    input  cmse_pkg::dp_cmd_t               cmd,
    output cmse_pkg::dp_status_t            status,
    input  logic                            seq_ready,
    output logic                            seq_valid,
    output logic [cmse_pkg::BYTE_W-1:0]     seq_byte,
    output logic                            last
);

    localparam int CNT_W = $clog2(MAX_DIGITS + 1);
    localparam logic [31:0] LIMIT = cmse_pkg::digit_limit(MAX_DIGITS);
    localparam int VW = cmse_pkg::VAL_W;
    localparam int PROD_W = VW + cmse_pkg::DIV10_MUL_W;

    logic [VW-1:0]                     value_reg;
    logic [VW-1:0]                     col_reg;
    logic [cmse_pkg::DIGIT_W-1:0]      digit_reg [MAX_DIGITS];
    logic [CNT_W-1:0]                  cnt_reg;
    logic                              valid_reg;
    logic [cmse_pkg::BYTE_W-1:0]       byte_reg;
    logic                              last_reg;

    logic [VW-1:0]                     row_sat;
    logic [VW-1:0]                     col_sat;
    logic [PROD_W-1:0]                 prod;
    logic [VW-1:0]                     quot;
    logic [VW-1:0]                     rem;
    logic [cmse_pkg::BYTE_W-1:0]       byte_next;

    assign row_sat = (32'(row) > LIMIT) ? LIMIT[VW-1:0] : row;
    assign col_sat = (32'(col_reg) > LIMIT) ? LIMIT[VW-1:0] : col_reg;

    // divide by ten through the reciprocal, remainder by shift-add
    assign prod = PROD_W'(value_reg) * PROD_W'(cmse_pkg::DIV10_MUL);
    assign quot = VW'(prod >> cmse_pkg::DIV10_SHIFT);
    assign rem  = value_reg - VW'((quot << 3) + (quot << 1));

    assign status.out_free  = !valid_reg || seq_ready;
    assign status.conv_done = (quot == '0) || (cnt_reg == CNT_W'(MAX_DIGITS - 1));
    assign status.pop_last  = (cnt_reg == CNT_W'(1));

    always_comb
    begin
        case (cmd.sel)
            cmse_pkg::SEL_ESC:   byte_next = cmse_pkg::ESC_BYTE;
            cmse_pkg::SEL_LBR:   byte_next = cmse_pkg::ASCII_LBR;
            cmse_pkg::SEL_DIGIT: byte_next = cmse_pkg::ASCII_ZERO
                                             + cmse_pkg::BYTE_W'(digit_reg[0]);
            cmse_pkg::SEL_SEMI:  byte_next = cmse_pkg::ASCII_SEMI;
            cmse_pkg::SEL_H:     byte_next = cmse_pkg::ASCII_H;
            default:             byte_next = cmse_pkg::ESC_BYTE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                cnt_reg <= '0;
            end
            else if (cmd.conv)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            else if (cmd.pop)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
            end

            if (cmd.emit)
            begin
                valid_reg <= 1'b1;
            end
            else if (seq_ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            value_reg <= row_sat;
            col_reg   <= column;
        end
        else if (cmd.load_col)
        begin
            value_reg <= col_sat;
        end
        else if (cmd.conv)
        begin
            value_reg <= quot;
        end

        // digit stack: push at the top while converting, pop from the top
        if (cmd.conv)
        begin
            digit_reg[0] <= cmse_pkg::DIGIT_W'(rem);
            for (int i = 1; i < MAX_DIGITS; i++)
            begin
                digit_reg[i] <= digit_reg[i-1];
            end
        end
        else if (cmd.pop)
        begin
            for (int i = 0; i < MAX_DIGITS - 1; i++)
            begin
                digit_reg[i] <= digit_reg[i+1];
            end
        end

        if (cmd.emit)
        begin
            byte_reg <= byte_next;
            last_reg <= (cmd.sel == cmse_pkg::SEL_H);
        end
    end

    assign seq_valid = valid_reg;
    assign seq_byte  = byte_reg;
    assign last      = last_reg;

    `CMSE_ASSERT_SAME(a_emit_free, clk, rst_n, cmd.emit, status.out_free, "emit into a full output register")
    `CMSE_ASSERT_SAME(a_pop_nonempty, clk, rst_n, cmd.pop, cnt_reg != '0, "pop from an empty digit stack")
    `CMSE_ASSERT_SAME(a_conv_room, clk, rst_n, cmd.conv, cnt_reg < CNT_W'(MAX_DIGITS), "digit stack overflow")
    `CMSE_ASSERT_NEXT(a_conv_count, clk, rst_n, cmd.conv && !cmd.load, cnt_reg == CNT_W'($past(cnt_reg) + CNT_W'(1)), "digit count did not advance")

endmodule

// File: rtl/cmse_ctrl.sv
// ---------------------------------------------------------------------------
// cmse_ctrl
// sequencer that steps through the bytes of one cursor move sequence
// ---------------------------------------------------------------------------
module cmse_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cmd_valid,
    output logic                  cmd_ready,
    input  cmse_pkg::dp_status_t  status,
    output cmse_pkg::dp_cmd_t     cmd
);

    cmse_pkg::state_t state_reg;
    cmse_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cmse_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        cmd.sel      = cmse_pkg::SEL_ESC;
        cmd_ready    = 1'b0;
        case (state_reg)
            cmse_pkg::ST_IDLE:
            begin
                cmd_ready = 1'b1;
                if (cmd_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = cmse_pkg::ST_ESC;
                end
            end
            cmse_pkg::ST_ESC:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.sel    = cmse_pkg::SEL_ESC;
                    state_next = cmse_pkg::ST_LBR;
                end
            end
            cmse_pkg::ST_LBR:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.sel    = cmse_pkg::SEL_LBR;
                    state_next = cmse_pkg::ST_ROW_CONV;
                end
            end
            cmse_pkg::ST_ROW_CONV:
            begin
                cmd.conv = 1'b1;
                if (status.conv_done)
                begin
                    state_next = cmse_pkg::ST_ROW_EMIT;
                end
            end
            cmse_pkg::ST_ROW_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit = 1'b1;
                    cmd.pop  = 1'b1;
                    cmd.sel  = cmse_pkg::SEL_DIGIT;
                    if (status.pop_last)
                    begin
                        state_next = cmse_pkg::ST_SEMI;
                    end
                end
            end
            cmse_pkg::ST_SEMI:
            begin
                if (status.out_free)
                begin
                    cmd.emit     = 1'b1;
                    cmd.load_col = 1'b1;
                    cmd.sel      = cmse_pkg::SEL_SEMI;
                    state_next   = cmse_pkg::ST_COL_CONV;
                end
            end
            cmse_pkg::ST_COL_CONV:
            begin
                cmd.conv = 1'b1;
                if (status.conv_done)
                begin
                    state_next = cmse_pkg::ST_COL_EMIT;
                end
            end
            cmse_pkg::ST_COL_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit = 1'b1;
                    cmd.pop  = 1'b1;
                    cmd.sel  = cmse_pkg::SEL_DIGIT;
                    if (status.pop_last)
                    begin
                        state_next = cmse_pkg::ST_FIN;
                    end
                end
            end
            cmse_pkg::ST_FIN:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.sel    = cmse_pkg::SEL_H;
                    state_next = cmse_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = cmse_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/cursor_move_sequence_encoder.sv
// ---------------------------------------------------------------------------
// cursor_move_sequence_encoder
// turns a row/column pair into the ESC [ row ; column H byte sequence
// ---------------------------------------------------------------------------
// Usage:
//   A row/column pair is transferred on the cmd channel (cmd_valid/cmd_ready).
//   The bytes come out one per transfer on the seq channel (seq_valid /
//   seq_ready): ESC, '[', row digits, ';', column digits, 'H'. last is high on
//   the 'H' byte only. Numbers carry no leading zeros; values above
//   10^MAX_DIGITS-1 are written as that value.
//   cmd_ready is high only while no sequence is in progress; the next pair is
//   taken as soon as the 'H' byte sits in the output register.
//   ESC is loaded into the output register from the ESC state, which the
//   sequencer enters when the pair is transferred.
//   Each digit passes through the divide-by-ten step and is then emitted
//   from the digit stack.
//   A stall on seq_ready holds the byte in the output register and holds
//   the sequencer before its next byte; nothing is dropped.
//   Reset clears the sequencer and the output valid; no pair is pending.
// ---------------------------------------------------------------------------
module cursor_move_sequence_encoder #(
    parameter int MAX_DIGITS = cmse_pkg::DEFAULT_MAX_DIGITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cmd_valid,
    output logic                          cmd_ready,
    input  logic [cmse_pkg::VAL_W-1:0]    row,
    input  logic [cmse_pkg::VAL_W-1:0]    column,
    output logic                          seq_valid,
    input  logic                          seq_ready,
    output logic [cmse_pkg::BYTE_W-1:0]   seq_byte,
    output logic                          last
);

    cmse_pkg::dp_cmd_t    cmd;
    cmse_pkg::dp_status_t status;

    cmse_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .status    (status),
        .cmd       (cmd)
    );

    cmse_datapath #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .row       (row),
        .column    (column),
        .cmd       (cmd),
        .status    (status),
        .seq_ready (seq_ready),
        .seq_valid (seq_valid),
        .seq_byte  (seq_byte),
        .last      (last)
    );

endmodule
